// File: rtl/mqr_pkg.sv
// ============================================================================
// Max queue package
// Shared types and codes for the queue with running maximum and its cells.
// ============================================================================
package mqr_pkg;

    // Width of one stored value
    localparam int DATA_W = 32;

    // Operation codes carried in tuser of the input beat
    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    // Fault codes reported with every result
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_EMPTY = 2'd1;
    localparam logic [1:0] FAULT_FULL  = 2'd2;

    // Control broadcast along a chain in the cycle an operation is applied
    typedef struct packed {
        logic              enq;
        logic              shift;
        logic [DATA_W-1:0] value;
    } t_cell_ctl;

    // Content of one cell as seen by its neighbour
    typedef struct packed {
        logic              occ;
        logic [DATA_W-1:0] data;
    } t_cell_state;

    // Head of a chain: the first two cells and the keep flag of the first
    typedef struct packed {
        t_cell_state c0;
        t_cell_state c1;
        logic        keep0;
    } t_chain_head;

endpackage

// File: rtl/mqr_cell.sv
// ============================================================================
// Max queue cell
// One slot of a chain. On an enqueue it keeps its value, is pruned when the
// new value is larger, or takes the new value when it is the first slot that is free or pruned.
// On a shift it takes the content of its right-hand neighbour.
// ============================================================================
module mqr_cell import mqr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_prune,      // remove entries smaller than an enqueued value
    input  t_cell_ctl   i_ctl,
    input  logic        i_left_keep,  // left neighbour survives the enqueue
    input  t_cell_state i_right,      // content of the right neighbour
    output logic        o_keep,
    output t_cell_state o_state
);

    logic              r_occ;
    logic              n_occ;
    logic [DATA_W-1:0] r_data;
    logic [DATA_W-1:0] n_data;

    // An occupied entry survives unless pruning removes it for a larger value.
    assign o_keep = r_occ && !(i_prune && ($signed(r_data) < $signed(i_ctl.value)));

    // Next content of the slot.
    always_comb begin
        n_occ  = r_occ;
        n_data = r_data;
        if (i_ctl.enq) begin
            n_occ = o_keep || i_left_keep;
            if (i_left_keep && !o_keep) begin
                n_data = i_ctl.value;
            end
        end else if (i_ctl.shift) begin
            n_occ  = i_right.occ;
            n_data = i_right.data;
        end
    end

    // Occupancy flag is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    // The stored value needs no reset.
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_state.occ  = r_occ;
    assign o_state.data = r_data;

endmodule

// File: rtl/mqr_chain.sv
// ============================================================================
// Max queue chain
// A row of cells joined to their neighbours. Entry zero is the head; an
// enqueue fills the first free or pruned cell and a shift moves every cell one
// place towards the head.
// ============================================================================
module mqr_chain import mqr_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_prune,
    input  t_cell_ctl   i_ctl,
    output t_chain_head o_head
);

    t_cell_state w_state [DEPTH];
    logic        w_keep  [DEPTH];

    // Build the row; the head sees a permanent left neighbour and the tail an
    // empty right neighbour.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic        w_left_keep;
        t_cell_state w_right;

        if (g == 0) begin : g_first
            assign w_left_keep = 1'b1;
        end else begin : g_inner
            assign w_left_keep = w_keep[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_body
            assign w_right = w_state[g+1];
        end

        mqr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_prune     (i_prune),
            .i_ctl       (i_ctl),
            .i_left_keep (w_left_keep),
            .i_right     (w_right),
            .o_keep      (w_keep[g]),
            .o_state     (w_state[g])
        );
    end

    assign o_head.c0    = w_state[0];
    assign o_head.c1    = w_state[1];
    assign o_head.keep0 = w_keep[0];

endmodule

// File: rtl/queue_with_running_max.sv
// A first-in first-out queue of signed 32-bit values that reports its current
// maximum with every result. Each input beat is an enqueue (tuser 0, value in
// tdata) or a dequeue (tuser 1); each produces exactly one registered result
// beat, carrying the dequeued value, the maximum and occupancy after
// the operation, and a fault code (dequeue on empty or enqueue on full, both
// leaving the queue unchanged). One beat is accepted every cycle while the
// result register is free or being drained: all stored values and all maximum
// candidates sit in two rows of cells that compare and shift in parallel, so
// the only limit on rate is the output side's tready.
// ============================================================================
// Queue with running maximum
// Top level: value chain, maximum candidate chain, count and result register.
// ============================================================================
module queue_with_running_max import mqr_pkg::*; #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input beats
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [DATA_W-1:0]     s_axis_tdata,   // [31:0] value
    input  logic                  s_axis_tuser,   // [0] command
    // Result beats
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // From bit 0 up: dequeued_value, dequeued_valid, current_max, max_valid,
    // occupancy, fault, zero padding to whole bytes.
    output logic [((2*DATA_W+4+$clog2(QUEUE_DEPTH+1)+7)/8)*8-1:0] m_axis_tdata
);

    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int OUT_W  = ((2 * DATA_W + 4 + CW + 7) / 8) * 8;
    localparam int POS_DV = DATA_W;
    localparam int POS_MX = DATA_W + 1;
    localparam int POS_MV = 2 * DATA_W + 1;
    localparam int POS_OC = 2 * DATA_W + 2;
    localparam int POS_FT = 2 * DATA_W + 2 + CW;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_m_valid;
    logic [OUT_W-1:0] r_m_data;
    logic [OUT_W-1:0] n_m_data;

    logic             w_accept;
    logic             w_is_enq;
    logic             w_empty;
    logic             w_full;
    logic             w_enq_ok;
    logic             w_deq_ok;
    logic             w_head_match;
    logic [1:0]       w_fault;
    t_cell_state      w_max_next;
    logic [DATA_W-1:0] w_max_out;

    t_cell_ctl        w_val_ctl;
    t_cell_ctl        w_cand_ctl;
    t_chain_head      w_val_head;
    t_chain_head      w_cand_head;

    // Handshake: take a beat whenever the result register is free or draining.
    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_is_enq      = (s_axis_tuser == CMD_ENQ);

    // Operation decode.
    assign w_empty      = (r_count == '0);
    assign w_full       = (r_count == CW'(QUEUE_DEPTH));
    assign w_enq_ok     = w_is_enq && !w_full;
    assign w_deq_ok     = !w_is_enq && !w_empty;
    assign w_head_match = w_cand_head.c0.occ && (w_cand_head.c0.data == w_val_head.c0.data);

    // Chain controls.
    assign w_val_ctl.enq    = w_accept && w_enq_ok;
    assign w_val_ctl.shift  = w_accept && w_deq_ok;
    assign w_val_ctl.value  = s_axis_tdata;
    assign w_cand_ctl.enq   = w_accept && w_enq_ok;
    assign w_cand_ctl.shift = w_accept && w_deq_ok && w_head_match;
    assign w_cand_ctl.value = s_axis_tdata;

    mqr_chain #(.DEPTH(QUEUE_DEPTH)) u_values (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prune (1'b0),
        .i_ctl   (w_val_ctl),
        .o_head  (w_val_head)
    );

    mqr_chain #(.DEPTH(QUEUE_DEPTH)) u_candidates (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_prune (1'b1),
        .i_ctl   (w_cand_ctl),
        .o_head  (w_cand_head)
    );

    // Count, fault and candidate head after the operation.
    always_comb begin
        n_count    = r_count;
        w_fault    = FAULT_NONE;
        w_max_next = w_cand_head.c0;
        if (w_is_enq) begin
            if (w_full) begin
                w_fault = FAULT_FULL;
            end else begin
                n_count = r_count + CW'(1);
                if (!w_cand_head.keep0) begin
                    w_max_next.occ  = 1'b1;
                    w_max_next.data = s_axis_tdata;
                end
            end
        end else begin
            if (w_empty) begin
                w_fault = FAULT_EMPTY;
            end else begin
                n_count = r_count - CW'(1);
                if (w_head_match) begin
                    w_max_next = w_cand_head.c1;
                end
            end
        end
    end

    assign w_max_out = (n_count != '0 && w_max_next.occ) ? w_max_next.data : '0;

    // Pack the result beat.
    always_comb begin
        n_m_data                         = '0;
        n_m_data[DATA_W-1:0]             = w_deq_ok ? w_val_head.c0.data : '0;
        n_m_data[POS_DV]                 = w_deq_ok;
        n_m_data[POS_MX +: DATA_W]       = w_max_out;
        n_m_data[POS_MV]                 = (n_count != '0);
        n_m_data[POS_OC +: CW]           = n_count;
        n_m_data[POS_FT +: 2]            = w_fault;
    end

    // Control state: count and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            if (w_accept) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_m_data <= n_m_data;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    // An accepted beat always yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> m_axis_tvalid)
        else $error("accepted beat produced no result");

    // The count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("occupancy beyond queue depth");

    // The value chain head is occupied exactly when the queue holds values.
    a_value_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_val_head.c0.occ == (r_count != '0))
        else $error("value chain out of step with count");

    // A non-empty queue always has at least one maximum candidate, and none
    // remain once it is empty.
    a_cand_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cand_head.c0.occ == (r_count != '0))
        else $error("candidate chain out of step with count");

endmodule
